// ===== rtl/core/u8je_pkg.sv =====
// Shared types, codes and helpers for the UTF-8 to JSON escape converter.
// Used by u8je_decode, u8je_emit and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8je_pkg;

  // what the main part of one request turns into
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ASCII = 3'd1,
    KIND_ERR   = 3'd2,
    KIND_UNIT  = 3'd3,
    KIND_PAIR  = 3'd4
  } kind_e;

  localparam logic [6:0] CHAR_BSL = 7'h5C;
  localparam logic [6:0] CHAR_U   = 7'h75;
  localparam logic [3:0] UNIT_LEN = 4'd6;

  // decoded description of all results caused by one input request
  typedef struct packed {
    logic        pre_err;   // open sequence cut short by this byte
    kind_e       kind;
    logic [6:0]  ascii;
    logic [15:0] hi_unit;   // BMP unit or high surrogate
    logic [15:0] lo_unit;   // low surrogate
    logic        post_err;  // sequence still open at line end
    logic        line_end;
    logic [3:0]  count;     // total results, 0..12
  } job_t;

  function automatic logic [3:0] main_len(kind_e k);
    logic [3:0] len;
    case (k)
      KIND_ASCII: len = 4'd1;
      KIND_ERR:   len = 4'd1;
      KIND_UNIT:  len = UNIT_LEN;
      KIND_PAIR:  len = 4'd12;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  // lowercase hex digit
  function automatic logic [6:0] hex_char(logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8_to_json_unicode_escape.sv =====
// UTF-8 to JSON \uXXXX escape converter, top level.
// Each result passes through the job slot and then the output register.
// Throughput: one result per cycle from the job sequencer while the output is not stalled;
// a new input byte is taken only as its last result is sent (1 for ASCII, 6 for BMP, 12 for a pair).
// Reset: asynchronous active low; clears the open sequence and all valids.
// Depends on u8je_pkg, u8je_decode and u8je_emit.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_json_unicode_escape (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // line_end
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [6:0] out_byte, [7] run_last
  output logic            m_axis_tlast_o,   // line_done
  output logic            m_axis_tuser_o    // [0] bad_sequence
);
  import u8je_pkg::*;

  job_t       job;
  logic       take;
  logic       accept;
  logic [6:0] out_byte;
  logic       run_last;

  assign accept          = s_axis_tvalid_i && take;
  assign s_axis_tready_o = take;

  // byte decode and sequence state
  u8je_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (s_axis_tdata_i),
    .line_end_i (s_axis_tlast_i),
    .job_o      (job)
  );

  // result sequencing
  u8je_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_i       (job),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (out_byte),
    .run_last_o  (run_last),
    .line_done_o (m_axis_tlast_o),
    .bad_o       (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {run_last, out_byte};

endmodule

`default_nettype wire

// ===== rtl/core/u8je_decode.sv =====
// Input decoder: holds the open UTF-8 sequence and turns one byte into a job.
// Depends on u8je_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8je_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          line_end_i,
  output u8je_pkg::job_t     job_o
);
  import u8je_pkg::*;

  logic [20:0] pcp_q, pcp_d;
  logic [1:0]  rem_q, rem_d;
  logic [20:0] cp_new;
  logic [20:0] cp_off;
  kind_e       kind;
  logic        pre_err, post_err;

  // gather bits and classify the byte
  always_comb begin
    cp_new   = {pcp_q[14:0], in_byte_i[5:0]};
    pcp_d    = pcp_q;
    rem_d    = rem_q;
    kind     = KIND_NONE;
    pre_err  = 1'b0;
    post_err = 1'b0;
    if (in_byte_i[7:6] == 2'b10) begin
      if (rem_q == 2'd0) begin
        kind = KIND_ERR;
      end else begin
        pcp_d = cp_new;
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          kind  = (cp_new > 21'h00FFFF) ? KIND_PAIR : KIND_UNIT;
          pcp_d = '0;
        end
      end
    end else begin
      pre_err = (rem_q != 2'd0);
      pcp_d   = '0;
      rem_d   = 2'd0;
      if (!in_byte_i[7]) begin
        kind = KIND_ASCII;
      end else if (in_byte_i < 8'hE0) begin
        pcp_d = {16'd0, in_byte_i[4:0]};
        rem_d = 2'd1;
      end else if (in_byte_i < 8'hF0) begin
        pcp_d = {17'd0, in_byte_i[3:0]};
        rem_d = 2'd2;
      end else if (in_byte_i < 8'hF5) begin
        pcp_d = {18'd0, in_byte_i[2:0]};
        rem_d = 2'd3;
      end else begin
        kind = KIND_ERR;
      end
    end
    // sequence left open at line end
    if (line_end_i && (rem_d != 2'd0)) begin
      post_err = 1'b1;
      pcp_d    = '0;
      rem_d    = 2'd0;
    end
  end

  // utf-16 units
  assign cp_off = cp_new - 21'h010000;

  always_comb begin
    job_o.pre_err  = pre_err;
    job_o.kind     = kind;
    job_o.ascii    = in_byte_i[6:0];
    job_o.hi_unit  = (kind == KIND_PAIR) ? (16'hD800 + {5'd0, cp_off[20:10]})
                                         : cp_new[15:0];
    job_o.lo_unit  = {6'b110111, cp_off[9:0]};
    job_o.post_err = post_err;
    job_o.line_end = line_end_i;
    job_o.count    = {3'd0, pre_err} + main_len(kind) + {3'd0, post_err};
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q <= '0;
      rem_q <= '0;
    end else if (accept_i) begin
      pcp_q <= pcp_d;
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8je_emit.sv =====
// Result sequencer: holds one job and sends its bytes one per cycle, while the output is not
// stalled, into an output register. Depends on u8je_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8je_emit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire u8je_pkg::job_t job_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [6:0]         out_byte_o,
  output logic               run_last_o,
  output logic               line_done_o,
  output logic               bad_o
);
  import u8je_pkg::*;

  job_t        job_q, job_d;
  logic        jvld_q, jvld_d;
  logic [3:0]  idx_q, idx_d;
  logic        ovld_q;
  logic [6:0]  obyte_q;
  logic        olast_q, oline_q, obad_q;

  logic        load_out, emit, last_slot;
  logic [3:0]  off, pos, mlen;
  logic [15:0] unit;
  logic [6:0]  s_byte;
  logic        s_bad;

  assign load_out  = !ovld_q || out_ready_i;
  assign emit      = jvld_q && load_out;
  assign last_slot = (idx_q == (job_q.count - 4'd1));
  assign take_o    = !jvld_q || (emit && last_slot);

  // pick the byte for the current slot
  always_comb begin
    mlen   = main_len(job_q.kind);
    off    = idx_q - {3'd0, job_q.pre_err};
    pos    = (off < UNIT_LEN) ? off : (off - UNIT_LEN);
    unit   = (off < UNIT_LEN) ? job_q.hi_unit : job_q.lo_unit;
    s_byte = 7'd0;
    s_bad  = 1'b0;
    if (job_q.pre_err && (idx_q == 4'd0)) begin
      s_bad = 1'b1;
    end else if (off < mlen) begin
      case (job_q.kind)
        KIND_ASCII: s_byte = job_q.ascii;
        KIND_ERR:   s_bad  = 1'b1;
        default: begin
          case (pos)
            4'd0:    s_byte = CHAR_BSL;
            4'd1:    s_byte = CHAR_U;
            4'd2:    s_byte = hex_char(unit[15:12]);
            4'd3:    s_byte = hex_char(unit[11:8]);
            4'd4:    s_byte = hex_char(unit[7:4]);
            default: s_byte = hex_char(unit[3:0]);
          endcase
        end
      endcase
    end else begin
      s_bad = 1'b1;
    end
  end

  // job slot and slot counter
  always_comb begin
    job_d  = job_q;
    jvld_d = jvld_q;
    idx_d  = idx_q;
    if (take_o) begin
      job_d  = job_i;
      jvld_d = accept_i && (job_i.count != 4'd0);
      idx_d  = 4'd0;
    end else if (emit) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jvld_q <= 1'b0;
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      jvld_q <= jvld_d;
      idx_q  <= idx_d;
      if (load_out) begin
        ovld_q <= emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      obyte_q <= s_byte;
      olast_q <= last_slot;
      oline_q <= last_slot && job_q.line_end;
      obad_q  <= s_bad;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign run_last_o  = olast_q;
  assign line_done_o = oline_q;
  assign bad_o       = obad_q;

endmodule

`default_nettype wire

// ===== dv/utf8_to_json_unicode_escape_tb.sv =====
// Testbench for utf8_to_json_unicode_escape: directed and random UTF-8 byte streams with
// random stalls on both stream sides, each output byte checked against a built-in predictor.
// Needs only the RTL of the block.
`timescale 1ns / 1ps

module utf8_to_json_unicode_escape_tb;

  // one predicted output byte
  typedef struct {
    logic [6:0] ch;
    logic       run_last;
    logic       line_done;
    logic       bad;
  } out_char_t;

  localparam logic [8*16-1:0] HEX_DIGITS = "0123456789abcdef";

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast_i = 1'b0;    // line_end
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b1;
  logic [7:0] m_axis_tdata_o;           // [6:0] out_byte, [7] run_last
  logic       m_axis_tlast_o;           // line_done
  logic       m_axis_tuser_o;           // [0] bad_sequence

  // predictor state: code point bits gathered and continuation bytes still due
  logic [20:0] cp_acc = '0;
  logic [1:0]  cont_left = '0;

  out_char_t step_chars[$];
  out_char_t pending_chars[$];
  out_char_t got_char;
  int        errors = 0;
  int        tx_burst = 0;
  int        rx_burst = 0;

  utf8_to_json_unicode_escape u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // idle cycles before the next request; now and then a stretch with no idling
  function automatic int draw_wait(inout int burst);
    int w;
    if (burst > 0) begin
      burst = burst - 1;
      w = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(10, 30);
      w = 0;
    end else begin
      w = $urandom_range(0, 18);
    end
    return w;
  endfunction

  task automatic add_char(input logic [6:0] ch, input logic bad);
    out_char_t c;
    c.ch = ch;
    c.run_last = 1'b0;
    c.line_done = 1'b0;
    c.bad = bad;
    step_chars.push_back(c);
  endtask

  // backslash, u and four lowercase hex digits of one utf-16 unit
  task automatic add_unit(input logic [15:0] unit);
    logic [3:0] nib;
    add_char(7'h5C, 1'b0);
    add_char(7'h75, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      nib = unit[4*i +: 4];
      add_char(HEX_DIGITS[8*(15 - nib) +: 7], 1'b0);
    end
  endtask

  // expected output bytes for one accepted input byte
  task automatic predict_escape(input logic [7:0] b, input logic eol);
    logic [20:0] off;
    step_chars.delete();
    if (b[7:6] == 2'b10) begin
      if (cont_left == 2'd0) begin
        add_char(7'd0, 1'b1);
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          if (cp_acc > 21'h00FFFF) begin
            off = cp_acc - 21'h010000;
            add_unit(16'hD800 + {5'd0, off[20:10]});
            add_unit(16'hDC00 + {6'd0, off[9:0]});
          end else begin
            add_unit(cp_acc[15:0]);
          end
          cp_acc = '0;
        end
      end
    end else begin
      // open sequence cut short by this byte
      if (cont_left != 2'd0) begin
        add_char(7'd0, 1'b1);
        cp_acc = '0;
        cont_left = '0;
      end
      if (!b[7]) begin
        add_char(b[6:0], 1'b0);
      end else if (b < 8'hE0) begin
        cp_acc = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b < 8'hF0) begin
        cp_acc = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if (b < 8'hF5) begin
        cp_acc = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        add_char(7'd0, 1'b1);
      end
    end
    // sequence still open at line end
    if (eol && cont_left != 2'd0) begin
      add_char(7'd0, 1'b1);
      cp_acc = '0;
      cont_left = '0;
    end
    if (step_chars.size() > 0) begin
      step_chars[step_chars.size() - 1].run_last = 1'b1;
      step_chars[step_chars.size() - 1].line_done = eol;
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endtask

  // one input request, predicted once accepted
  task automatic send_byte(input logic [7:0] b, input logic eol);
    int gap;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eol;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_escape(b, eol);
  endtask

  // output side stalls
  initial begin
    int stall;
    forever begin
      stall = draw_wait(rx_burst);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // compare each output request with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected output byte 0x%02h", m_axis_tdata_o);
        errors++;
      end else begin
        got_char = pending_chars.pop_front();
        if (m_axis_tdata_o[6:0] !== got_char.ch) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", got_char.ch, m_axis_tdata_o[6:0]);
          errors++;
        end
        if (m_axis_tdata_o[7] !== got_char.run_last) begin
          $error("run_last: expected %0b, got %0b", got_char.run_last, m_axis_tdata_o[7]);
          errors++;
        end
        if (m_axis_tlast_o !== got_char.line_done) begin
          $error("line_done: expected %0b, got %0b", got_char.line_done, m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tuser_o !== got_char.bad) begin
          $error("bad_sequence: expected %0b, got %0b", got_char.bad, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

  task automatic test_ascii_passthrough();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_bmp_escapes();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // surrogate code point and overlong form go through undecoded checks
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_surrogate_pairs();
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_malformed_input();
    // stray continuations and an invalid lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF5, 1'b0);
    // cut short by ascii, then by a new lead that completes
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // cut short by line end
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // mostly well-formed characters with random content, some truncated, some noise
  task automatic test_random_text(input int n_items);
    int         sent;
    int         pick;
    int         len;
    int         keep;
    logic       eol;
    logic [7:0] seq [0:3];
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (pick >= 85) begin
        len = 1;
      end else if (pick >= 70 && len == 1) begin
        len = 2;
      end
      case (len)
        1: seq[0] = (pick >= 85) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
        2: seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
        3: seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
        default: seq[0] = 8'hF0 + 8'($urandom_range(0, 4));
      endcase
      for (int i = 1; i < 4; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
      keep = (pick >= 70 && pick < 85) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < keep; i++) begin
        eol = (i == keep - 1) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 31) == 0);
        send_byte(seq[i], eol);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_ascii_passthrough();
    test_bmp_escapes();
    test_surrogate_pairs();
    test_malformed_input();
    test_random_text(140);
    s_axis_tvalid_i <= 1'b0;
    while (pending_chars.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== utf8_to_json_unicode_escape.f =====
rtl/core/u8je_pkg.sv
rtl/core/u8je_decode.sv
rtl/core/u8je_emit.sv
rtl/core/utf8_to_json_unicode_escape.sv
dv/utf8_to_json_unicode_escape_tb.sv
